/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// A condition that, when true, requires another in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// A condition that, when true, requires another in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/alst_pkg.sv */
package alst_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int MODE_W      = 2;
    localparam int ENTRY_CNT_W = 9;

    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [ID_W-1:0] PROTECTED_ROOT  = 32'd0;
    localparam logic [ID_W-1:0] PROTECTED_SHELL = 32'd2000;

    // Search item that walks along the row of cells, one cell per cycle.
    typedef struct packed {
        logic             vld;
        logic [ID_W-1:0]  id;
        logic             found;
        logic [IDX_W-1:0] slot;
        logic [ID_W-1:0]  last;
    } t_token;

    // Write broadcast to every cell; only the addressed cell takes it.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  data;
    } t_wr;

endpackage

/* hw/rtl/allowlist_set_table_top.sv */
// Allowlist of 32-bit user ids held in a row of TABLE_DEPTH cells, one id per
// cell. Each item (check, add or remove) is taken when the block is idle; its
// id then walks the row one cell per cycle, each cell comparing against its
// entry; the time of the search is set by the length of the cell row. The
// commit state then updates the table and fills the result register, waiting
// while the previous result has not yet been taken by the consumer. The next
// item is taken only once the block returns to idle after the commit, so the
// block holds one item at a time. Configuration writes are always taken.
module allowlist_set_table_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [alst_pkg::MODE_W-1:0]    i_mode,
    input  logic [alst_pkg::ID_W-1:0]      i_user_id,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_ok,
    output logic [alst_pkg::ENTRY_CNT_W-1:0] o_entry_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data
);
    import alst_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_enforce;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [MODE_W-1:0]   r_mode;
    t_token              r_res;
    logic                r_out_valid;
    logic                r_ok;
    logic                n_ok;
    t_wr                 w_wr;
    t_token              w_tok [0:TABLE_DEPTH];
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == S_COMMIT) && w_out_free;

    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].vld   = w_in_acc;
        w_tok[0].id    = i_user_id;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        alst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_wr    (w_wr)
        );
    end

    // Decide the outcome from the finished search and form the table write.
    always_comb begin
        n_ok    = 1'b0;
        n_count = r_count;
        w_wr    = '0;
        unique case (r_mode)
            MODE_CHECK: begin
                n_ok = !r_enforce || r_res.found;
            end
            MODE_ADD: begin
                if (r_res.found) begin
                    n_ok = 1'b1;
                end else if (r_count < CNT_W'(TABLE_DEPTH)) begin
                    n_ok       = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    w_wr.en    = w_commit;
                    w_wr.idx   = IDX_W'(r_count);
                    w_wr.data  = r_res.id;
                end
            end
            MODE_REMOVE: begin
                if ((r_res.id != PROTECTED_ROOT) && (r_res.id != PROTECTED_SHELL) &&
                    r_res.found && (r_count != '0)) begin
                    n_ok      = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                    w_wr.en   = w_commit;
                    w_wr.idx  = r_res.slot;
                    w_wr.data = r_res.last;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_SCAN;
            S_SCAN:   if (w_tok[TABLE_DEPTH].vld) n_state = S_COMMIT;
            S_COMMIT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enforce   <= 1'b1;
            r_count     <= CNT_W'(2);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_enforce <= i_cfg_data;
            end
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode <= i_mode;
        end
        if ((r_state == S_SCAN) && w_tok[TABLE_DEPTH].vld) begin
            r_res <= w_tok[TABLE_DEPTH];
        end
        if (w_commit) begin
            r_ok <= n_ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_entry_count = ENTRY_CNT_W'(r_count);

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_DEPTH), "count above depth")
    `ASSERT_SAME(a_tail_in_scan, i_clk, i_rst_n, w_tok[TABLE_DEPTH].vld, r_state == S_SCAN, "search item left the row outside a scan")
    `ASSERT_SAME(a_write_commit, i_clk, i_rst_n, w_wr.en, w_commit, "table written outside a commit")
    `ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !w_commit, $stable(r_count), "count changed without a commit")

endmodule

/* hw/rtl/alst_cell.sv */
module alst_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [alst_pkg::IDX_W-1:0] i_idx,
    input  logic [alst_pkg::CNT_W-1:0] i_count,
    input  alst_pkg::t_token      i_tok,
    output alst_pkg::t_token      o_tok,
    input  alst_pkg::t_wr         i_wr
);
    import alst_pkg::*;

    logic [ID_W-1:0] r_entry;
    t_token          r_tok;
    t_token          n_tok;
    logic            w_live;
    logic            w_last;

    // An entry takes part only while it lies below the fill count.
    assign w_live = CNT_W'(i_idx) < i_count;
    assign w_last = (CNT_W'(i_idx) + CNT_W'(1)) == i_count;

    always_comb begin
        n_tok = i_tok;
        if (w_live && (r_entry == i_tok.id) && !i_tok.found) begin
            n_tok.found = 1'b1;
            n_tok.slot  = i_idx;
        end
        if (w_last) begin
            n_tok.last = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= (i_idx == IDX_W'(1)) ? PROTECTED_SHELL : PROTECTED_ROOT;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_entry <= i_wr.data;
        end
    end

    assign o_tok = r_tok;

endmodule

/* test/allowlist_checker.sv */
module allowlist_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [alst_pkg::MODE_W-1:0]      i_mode,
    input  logic [alst_pkg::ID_W-1:0]        i_user_id,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_ok,
    input  logic [alst_pkg::ENTRY_CNT_W-1:0] i_entry_count,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic                             i_cfg_data,
    output int                               o_fail_count,
    output int                               o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import alst_pkg::*;

    typedef struct packed {
        logic                   ok;
        logic [ENTRY_CNT_W-1:0] count;
    } t_verdict;

    t_verdict         verdict_q[$];
    logic [ID_W-1:0]  allow_ids[TABLE_DEPTH];
    logic [CNT_W-1:0] allow_count;
    logic             enforce_on;
    int               fails   = 0;
    int               waiting = 0;

    assign o_fail_count = fails;
    assign o_waiting    = waiting;

    task automatic report_mismatch(input string msg);
        $display("%0t allowlist mismatch: %s", $time, msg);
        fails++;
    endtask

    // Slot of an id among the live entries, or -1 when it is not held.
    function automatic int position_of(input logic [ID_W-1:0] id);
        for (int i = 0; i < int'(allow_count); i++) begin
            if (allow_ids[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns its answer.
    function automatic t_verdict apply_request(input logic [MODE_W-1:0] mode,
                                               input logic [ID_W-1:0]   id);
        int       slot;
        t_verdict v;
        slot = position_of(id);
        v.ok = 1'b0;
        case (mode)
            MODE_CHECK: begin
                v.ok = !enforce_on || (slot >= 0);
            end
            MODE_ADD: begin
                if (slot >= 0) begin
                    v.ok = 1'b1;
                end else if (allow_count < TABLE_DEPTH) begin
                    allow_ids[allow_count] = id;
                    allow_count = allow_count + 1'b1;
                    v.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (id != PROTECTED_ROOT && id != PROTECTED_SHELL && slot >= 0) begin
                    // The last entry fills the hole left by the removed id.
                    allow_count = allow_count - 1'b1;
                    allow_ids[slot] = allow_ids[allow_count];
                    v.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        v.count = ENTRY_CNT_W'(allow_count);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            allow_ids[0] = PROTECTED_ROOT;
            allow_ids[1] = PROTECTED_SHELL;
            allow_count  = CNT_W'(2);
            enforce_on   = 1'b1;
            verdict_q.delete();
        end else begin
            // Results are matched before this edge's request is queued.
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result ok=%0b count=%0d with nothing pending",
                                              i_ok, i_entry_count));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_ok !== want.ok) begin
                        report_mismatch($sformatf("ok %0b, expected %0b", i_ok, want.ok));
                    end
                    if (i_entry_count !== want.count) begin
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  i_entry_count, want.count));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                enforce_on = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                verdict_q.push_back(apply_request(i_mode, i_user_id));
            end
        end
        waiting = verdict_q.size();
    end

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alst_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
    localparam int POOL_SIZE       = 320;
    localparam int PHASE_ITEMS     = 256;
    localparam int STALL_LIMIT     = 20000;
    localparam int PRESSURE_CYCLES = 1500;
    localparam int DRAIN_CYCLES    = 300;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      i_mode;
    logic [ID_W-1:0]        i_user_id;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_ok;
    logic [ENTRY_CNT_W-1:0] o_entry_count;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_data;

    int          fail_count;
    int          waiting;
    int unsigned results_taken = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned items_sent;
    int          burst_left;
    logic [ID_W-1:0] id_pool[POOL_SIZE];

    allowlist_set_table_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_user_id    (i_user_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ok         (o_ok),
        .o_entry_count(o_entry_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    allowlist_checker allow_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_user_id    (i_user_id),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_ok         (o_ok),
        .i_entry_count(o_entry_count),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            results_taken <= results_taken + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The consumer changes its stall style after each random stretch and, once,
    // holds off long enough for the block to stop taking new items.
    initial begin : receiver
        int  style;
        int  stretch;
        bit  pressured;
        pressured = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressured && results_taken >= 400) begin
                pressured = 1'b1;
                i_out_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
            end
            style   = $urandom_range(0, 2);
            stretch = $urandom_range(50, 600);
            repeat (stretch) begin
                case (style)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_user_id  <= id;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        burst_left--;
    endtask

    // The enforcement bit is only changed once every answer has been taken.
    task automatic settle_and_set_enforce(input logic value);
        i_in_valid <= 1'b0;
        while (results_taken != items_sent) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic run_mixed_phase(input int add_pct, input int remove_pct);
        int              r;
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                mode = MODE_ADD;
            end else if (r < add_pct + remove_pct) begin
                mode = MODE_REMOVE;
            end else if (r < 95) begin
                mode = MODE_CHECK;
            end else begin
                mode = MODE_RESERVED;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (r < 88) begin
                id = r[0] ? PROTECTED_SHELL : PROTECTED_ROOT;
            end else begin
                id = $urandom;
            end
            send_request(mode, id);
        end
    endtask

    initial begin
        logic enforce_plan[5];
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= MODE_CHECK;
        i_user_id   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        items_sent = 0;
        burst_left = 0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        settle_and_set_enforce(1'b1);
        send_request(MODE_CHECK, PROTECTED_ROOT);
        send_request(MODE_CHECK, PROTECTED_SHELL);
        send_request(MODE_CHECK, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 32'hFFFF_FFFF);
        send_request(MODE_ADD, PROTECTED_ROOT);
        send_request(MODE_REMOVE, PROTECTED_ROOT);
        send_request(MODE_REMOVE, PROTECTED_SHELL);
        send_request(MODE_RESERVED, 32'hA5A5_A5A5);
        send_request(MODE_ADD, 32'h8000_0000);
        send_request(MODE_ADD, 32'h0000_0001);
        // Removing a middle entry pulls the last one into its slot.
        send_request(MODE_REMOVE, 32'hFFFF_FFFF);
        send_request(MODE_CHECK, 32'h0000_0001);
        send_request(MODE_REMOVE, 32'h0000_0001);
        send_request(MODE_REMOVE, 32'h0000_0001);
        send_request(MODE_RESERVED, 32'h5A5A_5A5A);

        settle_and_set_enforce(1'b0);
        send_request(MODE_CHECK, 32'h1234_5678);
        send_request(MODE_CHECK, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 32'h7FFF_FFFE);
        send_request(MODE_REMOVE, 32'h7FFF_FFFE);
        send_request(MODE_REMOVE, PROTECTED_SHELL);
        send_request(MODE_RESERVED, 32'hFFFF_FFFF);

        settle_and_set_enforce(1'b1);
        send_request(MODE_CHECK, 32'h7FFF_FFFE);

        // Filling from the pool runs the table to capacity and then past it.
        for (int i = 0; i < 300; i++) begin
            send_request(MODE_ADD, id_pool[i]);
        end

        enforce_plan[0] = 1'b0;
        enforce_plan[1] = 1'b1;
        enforce_plan[2] = 1'b0;
        enforce_plan[3] = 1'b1;
        enforce_plan[4] = 1'($urandom_range(0, 1));
        for (int p = 0; p < 5; p++) begin
            settle_and_set_enforce(enforce_plan[p]);
            case (p % 3)
                0:       run_mixed_phase(15, 55);
                1:       run_mixed_phase(55, 15);
                default: run_mixed_phase(30, 30);
            endcase
        end

        i_in_valid <= 1'b0;
        while (results_taken != items_sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/alst_pkg.sv
hw/rtl/alst_cell.sv
hw/rtl/allowlist_set_table_top.sv
test/allowlist_checker.sv
test/tb_top.sv
